@@ rtl/core/slt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_pkg
// Shared widths, opcode and status codes and the cell control bundle of the
// sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef logic [OP_W-1:0]            opcode_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic signed [DATA_W-1:0]   value_t;
  typedef logic [COUNT_W-1:0]         count_t;

  localparam opcode_t OP_INSERT       = 3'd0;
  localparam opcode_t OP_REMOVE_FIRST = 3'd1;
  localparam opcode_t OP_REMOVE_LAST  = 3'd2;
  localparam opcode_t OP_REMOVE_VALUE = 3'd3;
  localparam opcode_t OP_SEARCH       = 3'd4;
  localparam opcode_t OP_CLEAR        = 3'd5;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;        // insert at the first cell not below the operand
    logic shl_all;    // every cell takes its right neighbour
    logic shl_upper;  // cells not below the operand take their right neighbour
    logic drop_last;  // topmost valid cell goes empty
    logic clr;        // all cells go empty
  } ctrl_t;

endpackage
`default_nettype wire

@@ rtl/core/slt_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_if
// Valid/ready channels of the sorted list table: operation in, result out.
// ----------------------------------------------------------------------------
interface slt_op_if;
  logic                valid;
  logic                ready;
  slt_pkg::opcode_t    opcode;
  slt_pkg::value_t     operand_value;

  modport source (output valid, output opcode, output operand_value, input ready);
  modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

interface slt_res_if;
  logic                valid;
  logic                ready;
  slt_pkg::status_t    status;
  slt_pkg::value_t     result_value;
  slt_pkg::count_t     entry_count;

  modport source (output valid, output status, output result_value,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input result_value,
                  input entry_count, output ready);
endinterface
`default_nettype wire

@@ rtl/core/slt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_cell
// One slot of the sorted row: holds a value and a valid flag, compares it
// with the broadcast operand and shifts with its neighbours.
// ----------------------------------------------------------------------------
module slt_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire slt_pkg::ctrl_t  ctrl,
  input  wire slt_pkg::value_t op_value,
  input  wire slt_pkg::value_t left_value,
  input  wire logic            left_valid,
  input  wire logic            left_gt,
  input  wire slt_pkg::value_t right_value,
  input  wire logic            right_valid,
  output slt_pkg::value_t      cell_value,
  output logic                 cell_valid,
  output logic                 cell_gt,
  output logic                 cell_eq
);

  slt_pkg::value_t value_r, value_nxt;
  logic            valid_r, valid_nxt;

  // operand sits above this entry (signed order)
  assign cell_gt = valid_r && (op_value > value_r);
  assign cell_eq = valid_r && (op_value == value_r);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    priority if (ctrl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctrl.ins) begin
      if (!cell_gt) begin
        value_nxt = left_gt ? op_value : left_value;
        valid_nxt = left_valid;
      end
    end else if (ctrl.shl_all || (ctrl.shl_upper && !cell_gt)) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end else if (ctrl.drop_last) begin
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign cell_value = value_r;
  assign cell_valid = valid_r;

endmodule
`default_nettype wire

@@ rtl/core/sorted_list_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// The result of an operation is registered and shown on out_chan in the cycle after its transfer.
// Throughput: one operation per cycle while out_chan takes its results; all cells compare
// against the operand at once, so the row of DEPTH cells settles every operation in parallel.
// A stalled result holds off only the next transfer while out_chan is not ready.
// Reset: count zero, every cell empty; stored values are left as they are
// and need no clearing pass.
// ----------------------------------------------------------------------------
// sorted_list_table_unit
// Sorted store of up to DEPTH signed values built as a row of compare-and-
// shift cells, with insert, remove first/last/value, search and clear.
// ----------------------------------------------------------------------------
module sorted_list_table_unit #(
  parameter int DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  slt_op_if.sink     in_chan,
  slt_res_if.source  out_chan
);

  localparam int CW = $clog2(DEPTH + 1);

  // Cell row signals
  slt_pkg::value_t cell_value [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_gt;
  logic [DEPTH-1:0] cell_eq;
  logic [DEPTH-1:0] cell_last;   // topmost valid cell
  slt_pkg::ctrl_t   ctrl;

  // Control and result registers
  logic [CW-1:0]      count_r, count_nxt;
  logic               out_valid_r;
  slt_pkg::status_t   status_r, status_nxt;
  slt_pkg::value_t    result_r, result_nxt;
  logic [CW+4:0]      count_ext;

  logic            in_xfer;
  logic            full;
  logic            empty;
  logic            found;
  slt_pkg::value_t last_value;

  // Output stage frees up whenever its result is being taken.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  assign full  = cell_valid[DEPTH-1];
  assign empty = !cell_valid[0];
  assign found = |cell_eq;

  // Largest value: select the cell at the top of the valid run.
  always_comb begin
    last_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_last[i]) last_value = last_value | cell_value[i];
    end
  end

  // Decode the transfer into a row command, status and returned value.
  always_comb begin
    ctrl       = '0;
    status_nxt = slt_pkg::ST_OK;
    result_nxt = in_chan.operand_value;
    count_nxt  = count_r;
    if (in_xfer) begin
      unique case (in_chan.opcode)
        slt_pkg::OP_INSERT: begin
          if (full) begin
            status_nxt = slt_pkg::ST_FULL;
          end else begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        slt_pkg::OP_REMOVE_FIRST: begin
          if (empty) begin
            status_nxt = slt_pkg::ST_EMPTY;
          end else begin
            ctrl.shl_all = 1'b1;
            result_nxt   = cell_value[0];
            count_nxt    = count_r - CW'(1);
          end
        end
        slt_pkg::OP_REMOVE_LAST: begin
          if (empty) begin
            status_nxt = slt_pkg::ST_EMPTY;
          end else begin
            ctrl.drop_last = 1'b1;
            result_nxt     = last_value;
            count_nxt      = count_r - CW'(1);
          end
        end
        slt_pkg::OP_REMOVE_VALUE: begin
          priority if (empty) begin
            status_nxt = slt_pkg::ST_EMPTY;
          end else if (found) begin
            // equal values are contiguous, so the first match is the first
            // cell the operand does not exceed
            ctrl.shl_upper = 1'b1;
            count_nxt      = count_r - CW'(1);
          end else begin
            status_nxt = slt_pkg::ST_NOT_FOUND;
          end
        end
        slt_pkg::OP_SEARCH: begin
          priority if (empty) begin
            status_nxt = slt_pkg::ST_EMPTY;
          end else if (!found) begin
            status_nxt = slt_pkg::ST_NOT_FOUND;
          end else begin
            status_nxt = slt_pkg::ST_OK;
          end
        end
        slt_pkg::OP_CLEAR: begin
          ctrl.clr  = 1'b1;
          count_nxt = '0;
        end
        default: begin
          // unused opcodes: no change, operand echoed
          status_nxt = slt_pkg::ST_OK;
        end
      endcase
    end
  end

  // Row of cells; at the left edge the neighbour is the operand, at the right edge an empty cell.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    slt_pkg::value_t l_value, r_value;
    logic            l_valid, l_gt, r_valid;

    if (i == 0) begin : g_left_edge
      assign l_value = in_chan.operand_value;
      assign l_valid = 1'b1;
      assign l_gt    = 1'b1;
    end else begin : g_left
      assign l_value = cell_value[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_gt    = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_right_edge
      assign r_value   = cell_value[i];
      assign r_valid   = 1'b0;
    end else begin : g_right
      assign r_value   = cell_value[i+1];
      assign r_valid   = cell_valid[i+1];
    end

    assign cell_last[i] = cell_valid[i] && !r_valid;

    slt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .op_value    (in_chan.operand_value),
      .left_value  (l_value),
      .left_valid  (l_valid),
      .left_gt     (l_gt),
      .right_value (r_value),
      .right_valid (r_valid),
      .cell_value  (cell_value[i]),
      .cell_valid  (cell_valid[i]),
      .cell_gt     (cell_gt[i]),
      .cell_eq     (cell_eq[i])
    );
  end

  // Count and output register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r <= status_nxt;
      result_r <= result_nxt;
    end
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // count reported modulo 32, as the result field is five bits wide
  assign count_ext             = (CW + 5)'(count_r);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = status_r;
  assign out_chan.result_value = result_r;
  assign out_chan.entry_count  = count_ext[4:0];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("cell valid flags disagree with entry count");

  a_valid_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_last) && (empty || $onehot(cell_last)))
    else $error("valid cells not a contiguous run from the low end");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_chan.opcode == slt_pkg::OP_INSERT) && full
    |=> (status_r == slt_pkg::ST_FULL) && (count_r == CW'(DEPTH)))
    else $error("insert into full store not flagged");

  a_sorted_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[1] |-> (cell_value[0] <= cell_value[1]))
    else $error("lowest two entries out of order");

endmodule
`default_nettype wire
